// ===== sv/assert_macros.svh =====
// Assertion macros for the semi-global alignment RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== sv/saas_pkg.sv =====
// Types, constants and arithmetic helpers for the alignment score block.
// No dependencies.
package saas_pkg;

    localparam int CODE_W = 5;
    localparam int VAL_W = 8;
    localparam int GAP_W = 10;
    localparam int WIDE_W = 34;

    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_DB = 2'd2;

    localparam logic signed [31:0] NEG_INF = -32'sd1073741824;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    // One column step as it travels down the chain of cells.
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic [CODE_W-1:0]          code;
        logic signed [31:0]         diag;
        logic signed [31:0]         up;
        logic signed [WIDE_W-1:0]   f;
        logic signed [31:0]         colmax;
    } wave_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic               clear;
        logic               load_en;
        logic [CODE_W-1:0]  load_code;
        logic               wr_sel_en;
        logic               wr_code_en;
        logic [CODE_W-1:0]  wr_code;
        logic [CODE_W-1:0]  wr_col;
        logic [VAL_W-1:0]   wr_val;
    } cell_ctl_t;

    function automatic logic signed [WIDE_W-1:0] max_w(
        input logic signed [WIDE_W-1:0] a,
        input logic signed [WIDE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > WIDE_W'(INT_MAX))
            r = INT_MAX;
        else if (v < WIDE_W'(INT_MIN))
            r = INT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/saas_cell.sv =====
// One query row of the alignment: holds its residue, substitution row, H and E.
// Depends on saas_pkg.
module saas_cell #(
    parameter int IDX = 0,
    parameter int ASIZE = 32,
    parameter int LENW = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  saas_pkg::wave_t     wave_in,
    output saas_pkg::wave_t     wave_out,
    input  saas_pkg::cell_ctl_t ctl,
    input  logic [LENW-1:0]     sel_idx,
    input  logic [LENW-1:0]     len,
    input  logic [saas_pkg::GAP_W-1:0] gap_open,
    input  logic [saas_pkg::GAP_W-1:0] gap_extend
);
    import saas_pkg::*;

    localparam int CW = (ASIZE > 1) ? $clog2(ASIZE) : 1;

    logic [CODE_W-1:0]          code_reg;
    logic signed [VAL_W-1:0]    row [ASIZE];
    logic signed [31:0]         h_reg;
    logic signed [31:0]         e_reg;
    wave_t                      wave_reg;
    wave_t                      wave_next;

    logic                       active;
    logic                       selected;
    logic signed [WIDE_W-1:0]   left;
    logic signed [WIDE_W-1:0]   e_old;
    logic signed [WIDE_W-1:0]   sc;
    logic signed [WIDE_W-1:0]   e_new;
    logic signed [WIDE_W-1:0]   f_new;
    logic signed [WIDE_W-1:0]   h_raw;
    logic signed [31:0]         h_sat;

    assign selected = (sel_idx == LENW'(IDX));
    assign active = wave_in.valid && (LENW'(IDX) < len);

    always_comb
    begin
        left = wave_in.first ? '0 : WIDE_W'(h_reg);
        e_old = wave_in.first ? WIDE_W'(NEG_INF) : WIDE_W'(e_reg);
        if (({1'b0, code_reg} < 6'(ASIZE)) && ({1'b0, wave_in.code} < 6'(ASIZE)))
            sc = WIDE_W'(row[wave_in.code[CW-1:0]]);
        else
            sc = '0;
        e_new = max_w(e_old - WIDE_W'(gap_extend), left - WIDE_W'(gap_open));
        f_new = max_w(wave_in.f - WIDE_W'(gap_extend),
                      WIDE_W'(wave_in.up) - WIDE_W'(gap_open));
        h_raw = max_w(max_w(WIDE_W'(wave_in.diag) + sc, e_new), f_new);
        h_sat = sat32(h_raw);
        wave_next = wave_in;
        if (active)
        begin
            wave_next.diag = left[31:0];
            wave_next.up = h_sat;
            wave_next.f = f_new;
            wave_next.colmax = (h_sat > wave_in.colmax) ? h_sat : wave_in.colmax;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
            h_reg <= '0;
            e_reg <= NEG_INF;
        end
        else
        begin
            wave_reg <= wave_next;
            if (ctl.clear)
            begin
                h_reg <= '0;
                e_reg <= NEG_INF;
            end
            else if (active)
            begin
                h_reg <= h_sat;
                e_reg <= sat32(e_new);
            end
        end
    end

    // Residue code and substitution row; undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (ctl.load_en && selected)
            code_reg <= ctl.load_code;
        if ((ctl.wr_sel_en && selected) || (ctl.wr_code_en && code_reg == ctl.wr_code))
            row[ctl.wr_col[CW-1:0]] <= ctl.wr_val;
    end

    assign wave_out = wave_reg;

endmodule

// ===== sv/semiglobal_affine_alignment_score.sv =====
// A database beat walks the chain of MAX_QUERY cells, one cell per cycle, and its column
// maximum is taken at the tail; one beat is in flight at a time. The input takes no new
// beat until the current one is done: a database beat holds it until its column reaches
// the tail, and a final beat until its result is loaded into the output register; a query
// beat holds it while its substitution row is copied; a table beat is taken while idle.
// Reset: rst_n clears control, query length, H and E; the table is undefined until written.
module semiglobal_affine_alignment_score #(
    parameter int MAX_QUERY = 256,
    parameter int ALPHABET = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // code_a[4:0], code_b[9:5], table_value[17:10]
    input  logic [2:0]  s_tuser,    // kind[1:0], first[2]
    input  logic        s_tlast,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // score[31:0]
    output logic        m_tuser,    // no_query[0]
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import saas_pkg::*;

    `include "assert_macros.svh"

    // Codes are five bits wide, so at most 32 symbols are ever addressed.
    localparam int ASIZE = (ALPHABET < 32) ? ALPHABET : 32;
    localparam int CW = (ASIZE > 1) ? $clog2(ASIZE) : 1;
    localparam int TDEPTH = ASIZE * ASIZE;
    localparam int TW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int LENW = $clog2(MAX_QUERY + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_WAVE = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [GAP_W-1:0]       gap_open_reg, gap_extend_reg;
    logic [LENW-1:0]        len_reg, len_next;
    logic signed [31:0]     lrb_reg, lrb_next;
    logic                   last_reg, last_next;
    logic [LENW-1:0]        ld_idx_reg, ld_idx_next;
    logic [CODE_W-1:0]      ld_code_reg, ld_code_next;
    logic [CW-1:0]          ld_col_reg, ld_col_next;
    logic                   ld_issue_reg, ld_issue_next;
    logic                   ld_pend_reg, ld_pend_next;
    logic [CW-1:0]          ld_wcol_reg, ld_wcol_next;
    logic signed [31:0]     res_score_reg, res_score_next;
    logic                   res_nq_reg, res_nq_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    // Substitution table memory, read during the row copy.
    logic [VAL_W-1:0]       tbl_mem [TDEPTH];
    logic [VAL_W-1:0]       tbl_q_reg;
    logic                   tbl_we;
    logic [TW-1:0]          tbl_wa, tbl_ra;

    logic [1:0]             in_kind;
    logic [CODE_W-1:0]      in_a, in_b;
    logic [VAL_W-1:0]       in_val;
    logic                   in_first, accept;
    logic                   a_ok, b_ok;

    wave_t                  wave [MAX_QUERY+1];
    wave_t                  tail;
    cell_ctl_t              ctl;
    logic signed [31:0]     lrb_upd;

    assign in_kind = s_tuser[1:0];
    assign in_first = s_tuser[2];
    assign in_a = s_tdata[4:0];
    assign in_b = s_tdata[9:5];
    assign in_val = s_tdata[17:10];
    assign a_ok = {1'b0, in_a} < 6'(ASIZE);
    assign b_ok = {1'b0, in_b} < 6'(ASIZE);

    // The input side is open only while nothing is in flight; the output register
    // lets the next beat in while a result still waits.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;

    // Register port.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {22'd0, gap_extend_reg} : {22'd0, gap_open_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg <= GAP_W'(10);
            gap_extend_reg <= GAP_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                gap_extend_reg <= pwdata[GAP_W-1:0];
            else
                gap_open_reg <= pwdata[GAP_W-1:0];
        end
    end

    assign tbl_we = accept && (in_kind == KIND_TABLE) && a_ok && b_ok;
    assign tbl_wa = TW'(in_a[CW-1:0]) * TW'(ASIZE) + TW'(in_b[CW-1:0]);
    assign tbl_ra = TW'(ld_code_reg[CW-1:0]) * TW'(ASIZE) + TW'(ld_col_reg);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= in_val;
        tbl_q_reg <= tbl_mem[tbl_ra];
    end

    // Broadcast control. Table writes also patch the rows of cells holding that code;
    // the row copy writes into the cell that has just taken a query residue.
    always_comb
    begin
        ctl.clear = accept && (in_kind == KIND_QUERY);
        ctl.load_en = (state_reg == ST_LOAD);
        ctl.load_code = ld_code_reg;
        ctl.wr_sel_en = ld_pend_reg;
        ctl.wr_code_en = tbl_we;
        ctl.wr_code = tbl_we ? in_a : ld_code_reg;
        ctl.wr_col = tbl_we ? in_b : CODE_W'(ld_wcol_reg);
        ctl.wr_val = tbl_we ? in_val : tbl_q_reg;
    end

    // Head of the chain: a fresh column with zero top row and no gap above.
    always_comb
    begin
        wave[0].valid = accept && (in_kind == KIND_DB);
        wave[0].first = in_first;
        wave[0].code = in_a;
        wave[0].diag = '0;
        wave[0].up = '0;
        wave[0].f = WIDE_W'(NEG_INF);
        wave[0].colmax = INT_MIN;
    end

    for (genvar g = 0; g < MAX_QUERY; g++)
    begin : g_cell
        saas_cell #(
            .IDX(g),
            .ASIZE(ASIZE),
            .LENW(LENW)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .wave_in(wave[g]),
            .wave_out(wave[g+1]),
            .ctl(ctl),
            .sel_idx(ld_idx_reg),
            .len(len_reg),
            .gap_open(gap_open_reg),
            .gap_extend(gap_extend_reg)
        );
    end

    assign tail = wave[MAX_QUERY];
    // At the tail, up holds H of the last active query row.
    assign lrb_upd = ((len_reg != '0) && (tail.up > lrb_reg)) ? tail.up : lrb_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        lrb_next = lrb_reg;
        last_next = last_reg;
        ld_idx_next = ld_idx_reg;
        ld_code_next = ld_code_reg;
        ld_col_next = ld_col_reg;
        ld_issue_next = ld_issue_reg;
        ld_pend_next = 1'b0;
        ld_wcol_next = ld_col_reg;
        res_score_next = res_score_reg;
        res_nq_next = res_nq_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        KIND_QUERY:
                        begin
                            lrb_next = NEG_INF;
                            if (in_first || (len_reg < LENW'(MAX_QUERY)))
                            begin
                                ld_idx_next = in_first ? '0 : len_reg;
                                ld_code_next = in_a;
                                ld_col_next = '0;
                                ld_issue_next = a_ok;
                                len_next = in_first ? LENW'(1) : len_reg + LENW'(1);
                                state_next = ST_LOAD;
                            end
                        end
                        KIND_DB:
                        begin
                            if (in_first)
                                lrb_next = NEG_INF;
                            last_next = s_tlast;
                            state_next = ST_WAVE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (ld_issue_reg)
                begin
                    ld_pend_next = 1'b1;
                    if (ld_col_reg == CW'(ASIZE - 1))
                        ld_issue_next = 1'b0;
                    else
                        ld_col_next = ld_col_reg + CW'(1);
                end
                else if (!ld_pend_reg)
                    state_next = ST_IDLE;
            end
            ST_WAVE:
            begin
                if (tail.valid)
                begin
                    lrb_next = lrb_upd;
                    res_nq_next = (len_reg == '0);
                    if (len_reg == '0)
                        res_score_next = '0;
                    else
                        res_score_next = (tail.colmax > lrb_upd) ? tail.colmax : lrb_upd;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = res_score_reg;
                    m_tuser_next = res_nq_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            lrb_reg <= NEG_INF;
            last_reg <= 1'b0;
            ld_issue_reg <= 1'b0;
            ld_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            lrb_reg <= lrb_next;
            last_reg <= last_next;
            ld_issue_reg <= ld_issue_next;
            ld_pend_reg <= ld_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_idx_reg <= ld_idx_next;
        ld_code_reg <= ld_code_next;
        ld_col_reg <= ld_col_next;
        ld_wcol_reg <= ld_wcol_next;
        res_score_reg <= res_score_next;
        res_nq_reg <= res_nq_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // A column reaches the tail only while the sequencer waits for it.
    `ASSERT_IMPLY(a_tail_in_wave, clk, rst_n, tail.valid, state_reg == ST_WAVE)
    // A new result is only ever loaded from the finishing state.
    `ASSERT_IMPLY(a_result_from_fin, clk, rst_n, $rose(m_tvalid_reg),
                  $past(state_reg) == ST_FIN)
    // The query never grows past the chain.
    `ASSERT_IMPLY(a_len_bound, clk, rst_n, 1'b1, len_reg <= LENW'(MAX_QUERY))
    // Row copy writes land only while loading.
    `ASSERT_NEXT(a_copy_in_load, clk, rst_n, ld_issue_reg && state_reg == ST_LOAD,
                 ld_pend_reg && state_reg == ST_LOAD)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the semi-global affine-gap alignment score block.
// Depends on saas_pkg and the semiglobal_affine_alignment_score RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import saas_pkg::*;

    localparam int QMAX = 256;
    localparam int ABC = 32;
    // A pause long enough for the chain to drain fully.
    localparam int DRAIN = QMAX + 40;
    localparam int ITEM_TARGET = 1950;

    localparam logic [2:0] ADDR_GAP_OPEN = 3'd0;
    localparam logic [2:0] ADDR_GAP_EXTEND = 3'd4;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // One input beat, field by field.
    typedef struct {
        logic [1:0]        kind;
        logic [4:0]        code_a;
        logic [4:0]        code_b;
        logic [7:0]        value;
        logic              first;
        logic              last;
    } beat_t;

    // One expected result beat.
    typedef struct {
        logic signed [31:0] score;
        logic               no_query;
    } score_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    semiglobal_affine_alignment_score dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Beats waiting to be driven, and scores waiting to come out.
    beat_t  pending_beats[$];
    score_t pending_scores[$];

    int errors = 0;
    int beats_pushed = 0;
    int db_beats = 0;
    int scores_seen = 0;
    int settings_used = 0;

    // Mirror of the block's state, kept by the alignment predictor.
    logic signed [7:0]  subst[ABC][ABC];
    bit                 subst_known[ABC][ABC];
    logic [4:0]         query[QMAX];
    int                 query_len = 0;
    longint             h_col[QMAX];
    longint             e_col[QMAX];
    longint             row_best;
    longint             gap_open_r = 10;
    longint             gap_extend_r = 1;

    // Codes whose table entries are all written: the only ones random phases use in queries and columns.
    int alphabet[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void clear_columns();
        for (int i = 0; i < QMAX; i++)
        begin
            h_col[i] = 0;
            e_col[i] = -64'sd1073741824;
        end
        row_best = -64'sd1073741824;
    endfunction

    // Applies one accepted beat to the mirror and queues any score it produces.
    function automatic void align_step(input beat_t b);
        longint diag;
        longint up;
        longint f;
        longint left;
        longint e;
        longint h;
        longint best;
        score_t r;
        diag = 0;
        up = 0;
        f = -64'sd1073741824;
        if (b.kind == KIND_TABLE)
        begin
            subst[b.code_a][b.code_b] = b.value;
            return;
        end
        if (b.kind == KIND_QUERY)
        begin
            if (b.first)
                query_len = 0;
            if (query_len < QMAX)
            begin
                query[query_len] = b.code_a;
                query_len++;
            end
            clear_columns();
            return;
        end
        if (b.kind != KIND_DB)
            return;
        db_beats++;
        if (b.first)
            clear_columns();
        for (int i = 0; i < query_len; i++)
        begin
            left = h_col[i];
            e = (e_col[i] - gap_extend_r > left - gap_open_r) ?
                e_col[i] - gap_extend_r : left - gap_open_r;
            f = (f - gap_extend_r > up - gap_open_r) ? f - gap_extend_r : up - gap_open_r;
            h = diag + longint'(subst[query[i]][b.code_a]);
            if (e > h)
                h = e;
            if (f > h)
                h = f;
            h = clamp32(h);
            e_col[i] = clamp32(e);
            h_col[i] = h;
            diag = left;
            up = h;
        end
        if (query_len > 0 && up > row_best)
            row_best = up;
        if (!b.last)
            return;
        if (query_len == 0)
        begin
            r.score = '0;
            r.no_query = 1'b1;
        end
        else
        begin
            best = row_best;
            for (int i = 0; i < query_len; i++)
                if (h_col[i] > best)
                    best = h_col[i];
            r.score = best[31:0];
            r.no_query = 1'b0;
        end
        pending_scores.push_back(r);
    endfunction

    // Driver: presents queued beats at the falling edge with random gaps between them.
    logic s_fire = 1'b0;
    int   send_gap = 0;

    always @(posedge clk)
    begin
        s_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            beat_t b;
            b.code_a = s_tdata[4:0];
            b.code_b = s_tdata[9:5];
            b.value = s_tdata[17:10];
            b.kind = s_tuser[1:0];
            b.first = s_tuser[2];
            b.last = s_tlast;
            align_step(b);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (send_gap > 0 || pending_beats.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else
            begin
                beat_t b;
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, b.value, b.code_b, b.code_a};
                s_tuser <= {b.first, b.kind};
                s_tlast <= b.last;
                // Long runs without any gap as well as gaps of random length.
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // Result side: random stall before each beat, checked at the rising edge.
    int recv_stall = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_tready && m_tvalid)
            begin
                m_tready <= 1'b0;
                recv_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            else if (recv_stall > 0)
                recv_stall <= recv_stall - 1;
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            scores_seen++;
            if (pending_scores.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result score=%0d no_query=%0b",
                         $realtime, $signed(m_tdata), m_tuser);
            end
            else
            begin
                score_t x;
                x = pending_scores.pop_front();
                if (m_tdata !== x.score || m_tuser !== x.no_query)
                begin
                    errors++;
                    $display("%0t: expected score=%0d no_query=%0b, got score=%0d no_query=%0b",
                             $realtime, x.score, x.no_query, $signed(m_tdata), m_tuser);
                end
            end
        end
    end

    task automatic push_beat(input logic [1:0] kind, input int ca, input int cb,
                             input int val, input bit first, input bit last);
        beat_t b;
        b.kind = kind;
        b.code_a = ca[4:0];
        b.code_b = cb[4:0];
        b.value = val[7:0];
        b.first = first;
        b.last = last;
        pending_beats.push_back(b);
        beats_pushed++;
    endtask

    // Waits until the block has been ready with nothing queued or owed for a whole
    // drain period, so that no column is still walking the chain.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN)
        begin
            @(posedge clk);
            if (pending_beats.size() == 0 && !s_tvalid && pending_scores.size() == 0 &&
                s_tready)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Register write followed by a read-back, both with setup and access cycles.
    task automatic reg_write(input logic [2:0] addr, input int value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[9:0] !== value[9:0])
        begin
            errors++;
            $display("%0t: register %0d read back expected %0d, got %0d",
                     $realtime, addr, value[9:0], prdata[9:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gaps(input int go, input int ge);
        wait_idle();
        reg_write(ADDR_GAP_OPEN, go);
        reg_write(ADDR_GAP_EXTEND, ge);
        gap_open_r = go;
        gap_extend_r = ge;
        settings_used++;
    endtask

    // Picks a fresh set of codes and writes every table entry between them not yet written.
    task automatic pick_alphabet(input int size);
        int c;
        alphabet.delete();
        while (alphabet.size() < size)
        begin
            c = $urandom_range(0, ABC - 1);
            if (!(c inside {alphabet}))
                alphabet.push_back(c);
        end
        foreach (alphabet[i])
            foreach (alphabet[j])
                if (!subst_known[alphabet[i]][alphabet[j]])
                begin
                    subst_known[alphabet[i]][alphabet[j]] = 1'b1;
                    push_beat(KIND_TABLE, alphabet[i], alphabet[j], $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                end
    endtask

    function automatic int any_code();
        return alphabet[$urandom_range(0, alphabet.size() - 1)];
    endfunction

    // A query of the given length and then a run of database columns, mostly well formed.
    task automatic alignment(input int qlen, input int cols);
        for (int i = 0; i < qlen; i++)
            push_beat(KIND_QUERY, any_code(), $urandom_range(0, 31), $urandom_range(0, 255),
                      i == 0, $urandom_range(0, 1));
        for (int j = 0; j < cols; j++)
        begin
            // The first column sometimes skips the restart so the previous alignment carries on.
            push_beat(KIND_DB, any_code(), $urandom_range(0, 31), $urandom_range(0, 255),
                      j == 0 && $urandom_range(0, 5) != 0,
                      j == cols - 1 || $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 15) == 0)
                push_beat(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
            if ($urandom_range(0, 20) == 0)
                push_beat(KIND_TABLE, any_code(), any_code(), $urandom_range(0, 255), 0, 0);
        end
    endtask

    int gap_settings[8][2] = '{'{10, 1}, '{0, 0}, '{1023, 1023}, '{1023, 0},
                               '{0, 1023}, '{3, 1}, '{12, 2}, '{1, 1}};

    initial
    begin
        for (int a = 0; a < ABC; a++)
            for (int b = 0; b < ABC; b++)
            begin
                subst[a][b] = '0;
                subst_known[a][b] = 1'b0;
            end
        clear_columns();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, with and without a restart, and a non-final column first.
        push_beat(KIND_DB, 31, 31, 255, 1'b0, 1'b1);
        push_beat(KIND_DB, 0, 0, 0, 1'b1, 1'b0);
        push_beat(KIND_DB, 5, 0, 0, 1'b1, 1'b1);
        // Table extremes, including the corner codes, and an ignored kind.
        alphabet = '{0, 31};
        push_beat(KIND_TABLE, 0, 0, 127, 1'b0, 1'b0);
        push_beat(KIND_TABLE, 0, 31, 128, 1'b1, 1'b1);
        push_beat(KIND_TABLE, 31, 0, 255, 1'b0, 1'b0);
        push_beat(KIND_TABLE, 31, 31, 0, 1'b0, 1'b0);
        foreach (subst_known[a, b])
            if ((a == 0 || a == 31) && (b == 0 || b == 31))
                subst_known[a][b] = 1'b1;
        push_beat(KIND_NONE, 31, 31, 255, 1'b1, 1'b1);
        // Query of one, then a second query beat restarting the load with last set.
        push_beat(KIND_QUERY, 31, 31, 255, 1'b1, 1'b0);
        push_beat(KIND_DB, 0, 31, 255, 1'b1, 1'b1);
        push_beat(KIND_QUERY, 0, 0, 0, 1'b1, 1'b1);
        push_beat(KIND_QUERY, 31, 0, 0, 1'b0, 1'b0);
        push_beat(KIND_DB, 31, 0, 0, 1'b0, 1'b0);
        push_beat(KIND_DB, 0, 0, 0, 1'b0, 1'b1);
        // Continue the finished alignment without a restart.
        push_beat(KIND_DB, 31, 0, 0, 1'b0, 1'b1);
        push_beat(KIND_DB, 0, 0, 0, 1'b1, 1'b1);

        // Random phases, each under a different pair of gap penalties.
        for (int p = 0; beats_pushed < ITEM_TARGET; p++)
        begin
            if (p < 8)
                set_gaps(gap_settings[p][0], gap_settings[p][1]);
            else
                set_gaps($urandom_range(0, 1023), $urandom_range(0, 1023));
            pick_alphabet($urandom_range(2, 8));
            if (p == 4)
                alignment(QMAX + 4, 3);     // query longer than the block holds
            repeat (6)
                if (beats_pushed < ITEM_TARGET)
                    alignment(($urandom_range(0, 9) == 0) ? $urandom_range(40, QMAX)
                                                          : $urandom_range(1, 12),
                              $urandom_range(1, 14));
        end

        wait_idle();
        $display("Covered %0d beats (%0d database columns), %0d results checked,",
                 beats_pushed, db_beats, scores_seen);
        $display("across %0d gap penalty settings including both extremes.", settings_used);
        if (errors == 0)
            $display("semiglobal_affine_alignment_score: match");
        else
            $display("semiglobal_affine_alignment_score: mismatch");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("semiglobal_affine_alignment_score: mismatch");
        $finish;
    end

endmodule

// ===== semiglobal_affine_alignment_score.f =====
+incdir+sv
sv/saas_pkg.sv
sv/saas_cell.sv
sv/semiglobal_affine_alignment_score.sv
sim/testbench.sv
